/* hdl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, pivot codes and sideband structs for the rotation matrix
// to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ELEM_W     = 16;           // Q2.14 element / component
    localparam int DIFF_W     = 17;           // sum or difference of two elements
    localparam int TRACE_W    = 18;
    localparam int RAD_W      = 20;
    localparam int RAD_KEEP_W = 17;           // radicand never exceeds 114687
    localparam int N_W        = 30;           // radicand << 12, even width
    localparam int P_W        = 15;           // rounded pivot
    localparam int SQ_STAGES  = N_W / 2;      // one root bit per stage
    localparam int REM_W      = P_W + 1;
    localparam int MAG_W      = 17;
    localparam int NUM_W      = 31;           // 2*mag*4096 + p
    localparam int DEN_W      = P_W + 1;      // 2*p
    localparam int DIV_STAGES = 24;           // quotient bits
    localparam int LANES      = 3;
    localparam logic signed [RAD_W-1:0] ONE_Q14 = RAD_W'(16384);

    typedef enum logic [1:0] {
        PIV_TRACE = 2'd0,
        PIV_R0C0  = 2'd1,
        PIV_R1C1  = 2'd2,
        PIV_R2C2  = 2'd3
    } t_pivot;

    typedef struct packed {
        t_pivot                   sel;
        logic                     inval;
        logic signed [DIFF_W-1:0] d_a;
        logic signed [DIFF_W-1:0] d_b;
        logic signed [DIFF_W-1:0] d_c;
    } t_sq_tag;

    typedef struct packed {
        t_pivot         sel;
        logic           inval;
        logic [P_W-1:0] p;
    } t_div_tag;

endpackage

/* hdl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// Trace, pivot choice, radicand and the three off-diagonal terms for the
// chosen case, two register stages.
// ----------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [ELEM_W-1:0] i_e00,
    input  logic signed [ELEM_W-1:0] i_e01,
    input  logic signed [ELEM_W-1:0] i_e02,
    input  logic signed [ELEM_W-1:0] i_e10,
    input  logic signed [ELEM_W-1:0] i_e11,
    input  logic signed [ELEM_W-1:0] i_e12,
    input  logic signed [ELEM_W-1:0] i_e20,
    input  logic signed [ELEM_W-1:0] i_e21,
    input  logic signed [ELEM_W-1:0] i_e22,
    output logic                     o_valid,
    output logic [N_W-1:0]           o_n,
    output t_sq_tag                  o_tag
);

    logic signed [RAD_W-1:0]   e00, e11, e22;
    t_pivot                    sel;
    logic signed [RAD_W-1:0]   rad;

    logic                      r_s1_vld, n_s1_vld;
    logic signed [TRACE_W-1:0] r_tr, n_tr, r_d00, n_d00, r_d11, n_d11, r_d22, n_d22;
    logic signed [RAD_W-1:0]   r_rad0, n_rad0, r_rad1, n_rad1;
    logic signed [RAD_W-1:0]   r_rad2, n_rad2, r_rad3, n_rad3;
    logic signed [DIFF_W-1:0]  r_dx, n_dx, r_dy, n_dy, r_dz, n_dz;
    logic signed [DIFF_W-1:0]  r_sxy, n_sxy, r_sxz, n_sxz, r_syz, n_syz;

    logic                      r_valid, n_valid;
    logic [N_W-1:0]            r_n, n_n;
    t_sq_tag                   r_tag, n_tag;

    always_comb begin
        e00      = RAD_W'(i_e00);
        e11      = RAD_W'(i_e11);
        e22      = RAD_W'(i_e22);
        n_s1_vld = i_valid;
        n_d00    = TRACE_W'(i_e00);
        n_d11    = TRACE_W'(i_e11);
        n_d22    = TRACE_W'(i_e22);
        n_tr     = n_d00 + n_d11 + n_d22;
        // radicand of every candidate, 2*diag - trace folded into one sum
        n_rad0   = e00 + e11 + e22 + ONE_Q14;
        n_rad1   = e00 - e11 - e22 + ONE_Q14;
        n_rad2   = e11 - e00 - e22 + ONE_Q14;
        n_rad3   = e22 - e00 - e11 + ONE_Q14;

        n_dx  = DIFF_W'(i_e21) - DIFF_W'(i_e12);
        n_dy  = DIFF_W'(i_e02) - DIFF_W'(i_e20);
        n_dz  = DIFF_W'(i_e10) - DIFF_W'(i_e01);
        n_sxy = DIFF_W'(i_e10) + DIFF_W'(i_e01);
        n_sxz = DIFF_W'(i_e02) + DIFF_W'(i_e20);
        n_syz = DIFF_W'(i_e21) + DIFF_W'(i_e12);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= n_s1_vld;
        end
        if (i_en) begin
            r_tr   <= n_tr;
            r_d00  <= n_d00;
            r_d11  <= n_d11;
            r_d22  <= n_d22;
            r_rad0 <= n_rad0;
            r_rad1 <= n_rad1;
            r_rad2 <= n_rad2;
            r_rad3 <= n_rad3;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_dz   <= n_dz;
            r_sxy  <= n_sxy;
            r_sxz  <= n_sxz;
            r_syz  <= n_syz;
        end
    end

    always_comb begin
        // first largest candidate wins, ties go to the earlier one
        if (r_d22 > r_tr && r_d22 > r_d00 && r_d22 > r_d11) begin
            sel = PIV_R2C2;
        end else if (r_d11 > r_tr && r_d11 > r_d00) begin
            sel = PIV_R1C1;
        end else if (r_d00 > r_tr) begin
            sel = PIV_R0C0;
        end else begin
            sel = PIV_TRACE;
        end
        case (sel)
            PIV_R0C0: rad = r_rad1;
            PIV_R1C1: rad = r_rad2;
            PIV_R2C2: rad = r_rad3;
            default:  rad = r_rad0;
        endcase

        n_valid     = r_s1_vld;
        n_tag.sel   = sel;
        n_tag.inval = (rad <= 0);
        n_n         = n_tag.inval ? '0 : {1'b0, rad[RAD_KEEP_W-1:0], 12'b0};
        // remaining components in ascending index order
        case (sel)
            PIV_TRACE: begin
                n_tag.d_a = r_dx;  n_tag.d_b = r_dy;  n_tag.d_c = r_dz;
            end
            PIV_R0C0: begin
                n_tag.d_a = r_dx;  n_tag.d_b = r_sxy; n_tag.d_c = r_sxz;
            end
            PIV_R1C1: begin
                n_tag.d_a = r_dy;  n_tag.d_b = r_sxy; n_tag.d_c = r_syz;
            end
            default: begin
                n_tag.d_a = r_dz;  n_tag.d_b = r_sxz; n_tag.d_c = r_syz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
        if (i_en) begin
            r_n   <= n_n;
            r_tag <= n_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_tag   = r_tag;

endmodule

/* hdl/rmq_sqrt.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined digit-by-digit square root, one root bit per stage, followed by
// a round-to-nearest stage.
// ----------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_n,
    input  t_sq_tag        i_tag,
    output logic           o_valid,
    output logic [P_W-1:0] o_p,
    output t_sq_tag        o_tag
);

    logic             r_vld  [SQ_STAGES+1];
    logic [N_W-1:0]   r_n    [SQ_STAGES+1];
    logic [REM_W-1:0] r_rem  [SQ_STAGES+1];
    logic [P_W-1:0]   r_root [SQ_STAGES+1];
    t_sq_tag          r_tag  [SQ_STAGES+1];
    logic             r_out_vld;
    logic [P_W-1:0]   r_p, n_p;
    t_sq_tag          r_out_tag;

    always_comb begin
        r_vld[0]  = i_valid;
        r_n[0]    = i_n;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_tag[0]  = i_tag;
    end

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [REM_W+1:0] t_rem, trial, diff;
        logic             ge;
        always_comb begin
            t_rem = {r_rem[k], r_n[k][N_W-1-2*k -: 2]};
            trial = {1'b0, r_root[k], 2'b01};
            ge    = (t_rem >= trial);
            diff  = t_rem - trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_n[k+1]    <= r_n[k];
                r_tag[k+1]  <= r_tag[k];
                r_rem[k+1]  <= ge ? diff[REM_W-1:0] : t_rem[REM_W-1:0];
                r_root[k+1] <= {r_root[k][P_W-2:0], ge};
            end
        end
    end

    // round up when the remainder exceeds the root
    always_comb begin
        n_p = r_root[SQ_STAGES] + P_W'(r_rem[SQ_STAGES] > REM_W'(r_root[SQ_STAGES]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[SQ_STAGES];
        end
        if (i_en) begin
            r_p       <= n_p;
            r_out_tag <= r_tag[SQ_STAGES];
        end
    end

    assign o_valid = r_out_vld;
    assign o_p     = r_p;
    assign o_tag   = r_out_tag;

endmodule

/* hdl/rmq_div.sv */
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider: d*4096/p rounded half away from
// zero, one quotient bit per stage, then a saturation stage.
// ----------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [P_W-1:0]           i_p,
    input  logic signed [DIFF_W-1:0] i_d [LANES],
    input  t_div_tag                 i_tag,
    output logic                     o_valid,
    output logic signed [ELEM_W-1:0] o_q [LANES],
    output t_div_tag                 o_tag
);

    logic                  r_vld [DIV_STAGES+1];
    t_div_tag              r_tag [DIV_STAGES+1];
    logic                  r_out_vld;
    t_div_tag              r_out_tag;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [NUM_W-1:0]      r_num [DIV_STAGES+1];
        logic [DEN_W-1:0]      r_den [DIV_STAGES+1];
        logic [DEN_W-1:0]      r_rem [DIV_STAGES+1];
        logic [DIV_STAGES-1:0] r_q   [DIV_STAGES+1];
        logic                  r_neg [DIV_STAGES+1];
        logic signed [DIFF_W:0] dext;
        logic [MAG_W-1:0]      mag;
        logic signed [ELEM_W-1:0] r_res, n_res;

        always_comb begin
            dext      = (DIFF_W+1)'(i_d[l]);
            mag       = dext[DIFF_W] ? MAG_W'(-dext) : MAG_W'(dext);
            r_neg[0]  = dext[DIFF_W];
            r_num[0]  = {1'b0, mag, 13'b0} + NUM_W'(i_p);
            r_den[0]  = {i_p, 1'b0};
            r_rem[0]  = DEN_W'(r_num[0][NUM_W-1:DIV_STAGES]);
            r_q[0]    = '0;
        end

        for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
            logic [DEN_W:0] t_rem, diff;
            logic           ge;
            always_comb begin
                t_rem = {r_rem[j], r_num[j][DIV_STAGES-1-j]};
                ge    = (t_rem >= {1'b0, r_den[j]});
                diff  = t_rem - {1'b0, r_den[j]};
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[j+1] <= r_num[j];
                    r_den[j+1] <= r_den[j];
                    r_neg[j+1] <= r_neg[j];
                    r_rem[j+1] <= ge ? diff[DEN_W-1:0] : t_rem[DEN_W-1:0];
                    r_q[j+1]   <= {r_q[j][DIV_STAGES-2:0], ge};
                end
            end
        end

        always_comb begin
            if (r_neg[DIV_STAGES]) begin
                if (r_q[DIV_STAGES] > DIV_STAGES'(32768)) begin
                    n_res = ELEM_W'(-32768);
                end else begin
                    n_res = -ELEM_W'(r_q[DIV_STAGES]);
                end
            end else if (r_q[DIV_STAGES] > DIV_STAGES'(32767)) begin
                n_res = ELEM_W'(32767);
            end else begin
                n_res = ELEM_W'(r_q[DIV_STAGES]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res <= n_res;
            end
        end

        assign o_q[l] = r_res;
    end

    always_comb begin
        r_vld[0] = i_valid;
        r_tag[0] = i_tag;
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
            if (i_en) begin
                r_tag[j+1] <= r_tag[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[DIV_STAGES];
        end
        if (i_en) begin
            r_out_tag <= r_tag[DIV_STAGES];
        end
    end

    assign o_valid = r_out_vld;
    assign o_tag   = r_out_tag;

endmodule

/* hdl/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q2.14 rotation matrix to a Q2.14 quaternion.
//
// Input channel: i_valid / o_stall with nine matrix elements; a transfer
// happens on a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with w, x, y, z, pivot_case, invalid.
// The pipeline has 2 front stages (trace and radicands, then pivot
// choice), 16 square root stages (one root bit each plus rounding), 25
// divider stages (one quotient bit each plus saturation) and the output
// register.
// Throughput is one item per cycle unless a stalled result freezes the
// pipeline; the three divisions run in parallel lanes.
// Synchronous active-low reset empties the pipeline; payload is not cleared.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and o_stall is raised in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [ELEM_W-1:0] i_elem_r0c0,
    input  logic signed [ELEM_W-1:0] i_elem_r0c1,
    input  logic signed [ELEM_W-1:0] i_elem_r0c2,
    input  logic signed [ELEM_W-1:0] i_elem_r1c0,
    input  logic signed [ELEM_W-1:0] i_elem_r1c1,
    input  logic signed [ELEM_W-1:0] i_elem_r1c2,
    input  logic signed [ELEM_W-1:0] i_elem_r2c0,
    input  logic signed [ELEM_W-1:0] i_elem_r2c1,
    input  logic signed [ELEM_W-1:0] i_elem_r2c2,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [ELEM_W-1:0] o_quat_w,
    output logic signed [ELEM_W-1:0] o_quat_x,
    output logic signed [ELEM_W-1:0] o_quat_y,
    output logic signed [ELEM_W-1:0] o_quat_z,
    output logic [1:0]               o_pivot_case,
    output logic                     o_invalid
);

    logic                     en;
    logic                     fr_vld, sq_vld, dv_vld;
    logic [N_W-1:0]           fr_n;
    t_sq_tag                  fr_tag, sq_tag;
    logic [P_W-1:0]           sq_p;
    logic signed [DIFF_W-1:0] dv_d [LANES];
    t_div_tag                 dv_in_tag, dv_tag;
    logic signed [ELEM_W-1:0] dv_q [LANES];
    logic signed [ELEM_W-1:0] pv;

    logic                     r_valid;
    logic signed [ELEM_W-1:0] r_w, r_x, r_y, r_z, n_w, n_x, n_y, n_z;
    logic [1:0]               r_piv;
    logic                     r_inval;

    assign en      = !(r_valid && i_stall);
    assign o_stall = r_valid && i_stall;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_e00   (i_elem_r0c0),
        .i_e01   (i_elem_r0c1),
        .i_e02   (i_elem_r0c2),
        .i_e10   (i_elem_r1c0),
        .i_e11   (i_elem_r1c1),
        .i_e12   (i_elem_r1c2),
        .i_e20   (i_elem_r2c0),
        .i_e21   (i_elem_r2c1),
        .i_e22   (i_elem_r2c2),
        .o_valid (fr_vld),
        .o_n     (fr_n),
        .o_tag   (fr_tag)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_vld),
        .i_n     (fr_n),
        .i_tag   (fr_tag),
        .o_valid (sq_vld),
        .o_p     (sq_p),
        .o_tag   (sq_tag)
    );

    always_comb begin
        dv_d[0]         = sq_tag.d_a;
        dv_d[1]         = sq_tag.d_b;
        dv_d[2]         = sq_tag.d_c;
        dv_in_tag.sel   = sq_tag.sel;
        dv_in_tag.inval = sq_tag.inval;
        dv_in_tag.p     = sq_p;
    end

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_p     (sq_p),
        .i_d     (dv_d),
        .i_tag   (dv_in_tag),
        .o_valid (dv_vld),
        .o_q     (dv_q),
        .o_tag   (dv_tag)
    );

    // pivot goes to its own slot, the lanes fill the rest in index order
    always_comb begin
        pv = ELEM_W'(dv_tag.p);
        case (dv_tag.sel)
            PIV_TRACE: begin
                n_w = pv;      n_x = dv_q[0]; n_y = dv_q[1]; n_z = dv_q[2];
            end
            PIV_R0C0: begin
                n_w = dv_q[0]; n_x = pv;      n_y = dv_q[1]; n_z = dv_q[2];
            end
            PIV_R1C1: begin
                n_w = dv_q[0]; n_x = dv_q[1]; n_y = pv;      n_z = dv_q[2];
            end
            default: begin
                n_w = dv_q[0]; n_x = dv_q[1]; n_y = dv_q[2]; n_z = pv;
            end
        endcase
        if (dv_tag.inval) begin
            n_w = '0; n_x = '0; n_y = '0; n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= dv_vld;
        end
        if (en) begin
            r_w     <= n_w;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_piv   <= dv_tag.sel;
            r_inval <= dv_tag.inval;
        end
    end

    assign o_valid      = r_valid;
    assign o_quat_w     = r_w;
    assign o_quat_x     = r_x;
    assign o_quat_y     = r_y;
    assign o_quat_z     = r_z;
    assign o_pivot_case = r_piv;
    assign o_invalid    = r_inval;

endmodule

/* hdl/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the quaternion converter, bound to the top level.
// ----------------------------------------------------------------------------
module rmq_checker
    import rmq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     o_stall,
    input  logic                     o_valid,
    input  logic                     i_stall,
    input  logic signed [ELEM_W-1:0] o_quat_w,
    input  logic signed [ELEM_W-1:0] o_quat_x,
    input  logic signed [ELEM_W-1:0] o_quat_y,
    input  logic signed [ELEM_W-1:0] o_quat_z,
    input  logic [1:0]               o_pivot_case,
    input  logic                     o_invalid
);

    // zeros on a bad radicand
    a_inval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |->
            o_quat_w == 0 && o_quat_x == 0 && o_quat_y == 0 && o_quat_z == 0)
        else $error("invalid result with nonzero components");

    // the pivot component is at least 64 when the radicand is positive
    a_pivot_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid |->
            (o_pivot_case == PIV_TRACE && o_quat_w >= 64) ||
            (o_pivot_case == PIV_R0C0  && o_quat_x >= 64) ||
            (o_pivot_case == PIV_R1C1  && o_quat_y >= 64) ||
            (o_pivot_case == PIV_R2C2  && o_quat_z >= 64))
        else $error("pivot component not positive");

    // input side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_quat_w) && $stable(o_quat_x)
            && $stable(o_quat_y) && $stable(o_quat_z) && $stable(o_invalid))
        else $error("stalled result changed");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_quat_w     (o_quat_w),
    .o_quat_x     (o_quat_x),
    .o_quat_y     (o_quat_y),
    .o_quat_z     (o_quat_z),
    .o_pivot_case (o_pivot_case),
    .o_invalid    (o_invalid)
);
